// File: design/mer_pkg.sv
// Package for the midpoint ellipse rasterizer: widths, phase and function codes,
// control word layout and the microprogram ROM of the sequencer.
// No dependencies; every other file of the block imports it.
package mer_pkg;

	localparam int RADIUS_BITS = 11;
	localparam int COORD_BITS  = 15;
	localparam int PIX_W       = 16;
	localparam int POS_W       = RADIUS_BITS + 2;
	localparam int SQ_W        = 2 * RADIUS_BITS;
	localparam int GRAD_W      = 3 * RADIUS_BITS + 3;
	localparam int TERM_W      = GRAD_W + 2;
	localparam int DEC_W       = 50;
	localparam int MUL_W       = 2 * RADIUS_BITS + 4;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int STEP_W      = 5;

	// Function codes of an input item.
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// Drawing phase.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_R1   = 2'd1;
	localparam logic [1:0] PH_R2   = 2'd2;

	typedef logic [3:0] mul_sel_t;
	typedef logic [3:0] dp_op_t;
	typedef logic [2:0] seq_t;
	typedef logic [STEP_W-1:0] step_t;

	// Multiplier operand pairs.
	localparam mul_sel_t MUL_NONE   = 4'd0;
	localparam mul_sel_t MUL_RXRX   = 4'd1;
	localparam mul_sel_t MUL_RYRY   = 4'd2;
	localparam mul_sel_t MUL_RX2RY  = 4'd3;
	localparam mul_sel_t MUL_TXTX   = 4'd4;
	localparam mul_sel_t MUL_TYTY   = 4'd5;
	localparam mul_sel_t MUL_RY2T   = 4'd6;
	localparam mul_sel_t MUL_RX2T   = 4'd7;
	localparam mul_sel_t MUL_RX2RY2 = 4'd8;

	// Register transfers of the datapath.
	localparam dp_op_t DP_NOP       = 4'd0;
	localparam dp_op_t DP_LOAD      = 4'd1;
	localparam dp_op_t DP_LD_RX2    = 4'd2;
	localparam dp_op_t DP_LD_RY2    = 4'd3;
	localparam dp_op_t DP_INIT_GRAD = 4'd4;
	localparam dp_op_t DP_ADD_RY2   = 4'd5;
	localparam dp_op_t DP_LD_T      = 4'd6;
	localparam dp_op_t DP_LD_DEC    = 4'd7;
	localparam dp_op_t DP_ADD_P     = 4'd8;
	localparam dp_op_t DP_SUB_P     = 4'd9;
	localparam dp_op_t DP_SETTLE    = 4'd10;
	localparam dp_op_t DP_ADV1      = 4'd11;
	localparam dp_op_t DP_ADV2      = 4'd12;
	localparam dp_op_t DP_HAND      = 4'd13;

	// Next-step selection.
	localparam seq_t SEQ_NEXT     = 3'd0;
	localparam seq_t SEQ_JUMP     = 3'd1;
	localparam seq_t SEQ_DISPATCH = 3'd2;
	localparam seq_t SEQ_SETTLE   = 3'd3;
	localparam seq_t SEQ_RETURN   = 3'd4;
	localparam seq_t SEQ_WAIT     = 3'd5;

	// Microprogram addresses.
	localparam step_t S_IDLE  = 5'd0;
	localparam step_t S_I1    = 5'd1;
	localparam step_t S_I2    = 5'd2;
	localparam step_t S_I3    = 5'd3;
	localparam step_t S_I4    = 5'd4;
	localparam step_t S_I5    = 5'd5;
	localparam step_t S_ST1   = 5'd6;
	localparam step_t S_T1    = 5'd7;
	localparam step_t S_T2    = 5'd8;
	localparam step_t S_T3    = 5'd9;
	localparam step_t S_T4    = 5'd10;
	localparam step_t S_T5    = 5'd11;
	localparam step_t S_T6    = 5'd12;
	localparam step_t S_STEND = 5'd13;
	localparam step_t S_HAND  = 5'd14;
	localparam step_t S_ADV1  = 5'd15;
	localparam step_t S_ADV2  = 5'd16;

	typedef struct packed {
		mul_sel_t mul;
		dp_op_t   dp;
		seq_t     seq;
		step_t    target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t addr);
		ucode_t w;
		w = '{mul: MUL_NONE, dp: DP_NOP, seq: SEQ_JUMP, target: S_IDLE};
		unique case (addr)
			S_IDLE:  w = '{mul: MUL_NONE,   dp: DP_LOAD,      seq: SEQ_DISPATCH, target: S_I1};
			S_I1:    w = '{mul: MUL_RXRX,   dp: DP_NOP,       seq: SEQ_NEXT,     target: S_IDLE};
			S_I2:    w = '{mul: MUL_RYRY,   dp: DP_LD_RX2,    seq: SEQ_NEXT,     target: S_IDLE};
			S_I3:    w = '{mul: MUL_RX2RY,  dp: DP_LD_RY2,    seq: SEQ_NEXT,     target: S_IDLE};
			S_I4:    w = '{mul: MUL_NONE,   dp: DP_INIT_GRAD, seq: SEQ_NEXT,     target: S_IDLE};
			S_I5:    w = '{mul: MUL_NONE,   dp: DP_ADD_RY2,   seq: SEQ_NEXT,     target: S_IDLE};
			S_ST1:   w = '{mul: MUL_NONE,   dp: DP_NOP,       seq: SEQ_SETTLE,   target: S_STEND};
			S_T1:    w = '{mul: MUL_TXTX,   dp: DP_NOP,       seq: SEQ_NEXT,     target: S_IDLE};
			S_T2:    w = '{mul: MUL_TYTY,   dp: DP_LD_T,      seq: SEQ_NEXT,     target: S_IDLE};
			S_T3:    w = '{mul: MUL_RY2T,   dp: DP_LD_T,      seq: SEQ_NEXT,     target: S_IDLE};
			S_T4:    w = '{mul: MUL_RX2T,   dp: DP_LD_DEC,    seq: SEQ_NEXT,     target: S_IDLE};
			S_T5:    w = '{mul: MUL_RX2RY2, dp: DP_ADD_P,     seq: SEQ_NEXT,     target: S_IDLE};
			S_T6:    w = '{mul: MUL_NONE,   dp: DP_SUB_P,     seq: SEQ_NEXT,     target: S_IDLE};
			S_STEND: w = '{mul: MUL_NONE,   dp: DP_SETTLE,    seq: SEQ_RETURN,   target: S_ADV1};
			S_HAND:  w = '{mul: MUL_NONE,   dp: DP_HAND,      seq: SEQ_WAIT,     target: S_IDLE};
			S_ADV1:  w = '{mul: MUL_NONE,   dp: DP_ADV1,      seq: SEQ_NEXT,     target: S_IDLE};
			S_ADV2:  w = '{mul: MUL_NONE,   dp: DP_ADV2,      seq: SEQ_JUMP,     target: S_ST1};
			default: w = '{mul: MUL_NONE,   dp: DP_NOP,       seq: SEQ_JUMP,     target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: design/mer_if.sv
// Handshake interfaces of the midpoint ellipse rasterizer: the command channel
// and the pixel channel. Depends on mer_pkg for the field widths.
interface mer_cmd_if import mer_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius_x;
	logic        [RADIUS_BITS-1:0] radius_y;

	modport source (output valid, func, center_x, center_y, radius_x, radius_y, input ready);
	modport sink   (input valid, func, center_x, center_y, radius_x, radius_y, output ready);
endinterface

interface mer_pix_if import mer_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [PIX_W-1:0] pixel_x;
	logic signed [PIX_W-1:0] pixel_y;
	logic                    last;
	logic                    done_res;

	modport source (output valid, pixel_x, pixel_y, last, done_res, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

// File: design/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer top level: microcoded sequencer, shared multiplier
// datapath and a four-pixel output stage. Depends on mer_pkg and mer_if.
//
// A start command latches center and semi-axes and yields the four mirrored pixels
// of the first position; each step command yields the four pixels of the next
// position, and nothing once the ellipse is finished (done_res marks the final
// position). A step command runs ADV1, ADV2, ST1 and STEND; a start first runs I1 to
// I5. Each region switch adds T1 to T6, as the region-two decision value is formed by
// five passes through the single 26x26 multiplier and a final subtraction. The four
// pixels of a position leave one per cycle while the sink is ready, from an output
// stage that drains while the sequencer already works on the next command.
module midpoint_ellipse_rasterizer import mer_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	mer_cmd_if.sink   cmd,
	mer_pix_if.source pix
);

	step_t  step_q, step_d;
	ucode_t uc;

	logic [1:0] phase_q;
	logic       fs_q;
	logic       br_q;

	logic signed [COORD_BITS-1:0]  ctr_x_q, ctr_y_q;
	logic        [RADIUS_BITS-1:0] rad_x_q, rad_y_q;
	logic        [SQ_W-1:0]        rx2_q, ry2_q;
	logic signed [POS_W-1:0]       px_q, py_q, snap_x_q, snap_y_q;
	logic signed [GRAD_W-1:0]      gx_q, gy_q;
	logic signed [DEC_W-1:0]       dec_q, p_q;
	logic signed [MUL_W-1:0]       t_q;

	logic                         busy_q;
	logic [1:0]                   cnt_q;
	logic signed [COORD_BITS-1:0] e_cx_q, e_cy_q;
	logic signed [POS_W-1:0]      e_ox_q, e_oy_q;
	logic                         e_done_q;

	logic cmd_xfer, pix_xfer, emit_free;
	logic r1, r2, active, r1_done, dec_pos, use_gx, use_gy;

	logic signed [MUL_W-1:0]  mul_a, mul_b, tx_m, ty_m;
	logic signed [PROD_W-1:0] prod;
	logic signed [GRAD_W-1:0] rx2_g2, ry2_g2;
	logic signed [DEC_W-1:0]  p4, rx2_d, ry2_4, term_4;
	logic signed [TERM_W-1:0] adv_term;
	logic signed [PIX_W-1:0]  cx_e, cy_e, ox_e, oy_e;

	assign uc = ucode_rom(step_q);

	assign cmd.ready = (uc.seq == SEQ_DISPATCH);
	assign cmd_xfer  = cmd.valid & cmd.ready;
	assign pix_xfer  = pix.valid & pix.ready;
	// The output stage can be reloaded in the cycle its fourth pixel transfers.
	assign emit_free = !busy_q || (pix_xfer && (cnt_q == 2'd3));

	assign r1      = (phase_q == PH_R1);
	assign r2      = (phase_q == PH_R2);
	assign active  = r1 || r2;
	assign r1_done = r1 && !(gx_q < gy_q);
	assign dec_pos = !dec_q[DEC_W-1] && (dec_q != '0);

	// Multiplier operands.
	assign tx_m = {{(MUL_W-POS_W-1){px_q[POS_W-1]}}, px_q, 1'b1};
	assign ty_m = $signed({{(MUL_W-POS_W){py_q[POS_W-1]}}, py_q}) - $signed(MUL_W'(1));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (uc.mul)
			MUL_RXRX: begin
				mul_a = $signed({{(MUL_W-RADIUS_BITS){1'b0}}, rad_x_q});
				mul_b = $signed({{(MUL_W-RADIUS_BITS){1'b0}}, rad_x_q});
			end
			MUL_RYRY: begin
				mul_a = $signed({{(MUL_W-RADIUS_BITS){1'b0}}, rad_y_q});
				mul_b = $signed({{(MUL_W-RADIUS_BITS){1'b0}}, rad_y_q});
			end
			MUL_RX2RY: begin
				mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, rx2_q});
				mul_b = $signed({{(MUL_W-RADIUS_BITS){1'b0}}, rad_y_q});
			end
			MUL_TXTX: begin
				mul_a = tx_m;
				mul_b = tx_m;
			end
			MUL_TYTY: begin
				mul_a = ty_m;
				mul_b = ty_m;
			end
			MUL_RY2T: begin
				mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, ry2_q});
				mul_b = t_q;
			end
			MUL_RX2T: begin
				mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, rx2_q});
				mul_b = t_q;
			end
			MUL_RX2RY2: begin
				mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, rx2_q});
				mul_b = $signed({{(MUL_W-SQ_W){1'b0}}, ry2_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign rx2_g2 = $signed({{(GRAD_W-SQ_W-1){1'b0}}, rx2_q, 1'b0});
	assign ry2_g2 = $signed({{(GRAD_W-SQ_W-1){1'b0}}, ry2_q, 1'b0});
	assign p4     = {p_q[DEC_W-3:0], 2'b00};
	assign rx2_d  = $signed({{(DEC_W-SQ_W){1'b0}}, rx2_q});
	assign ry2_4  = $signed({{(DEC_W-SQ_W-2){1'b0}}, ry2_q, 2'b00});

	// Second half of an advance. The branch taken in the first half selects which
	// gradients enter the decision update.
	assign use_gx   = r1 || !br_q;
	assign use_gy   = !r1 || !br_q;
	assign adv_term = (use_gx ? TERM_W'(gx_q) : '0) - (use_gy ? TERM_W'(gy_q) : '0)
		+ $signed({{(TERM_W-SQ_W){1'b0}}, (r1 ? ry2_q : rx2_q)});
	assign term_4   = {{(DEC_W-TERM_W-2){adv_term[TERM_W-1]}}, adv_term, 2'b00};

	// Sequencer.
	always_comb begin
		step_d = step_q;
		unique case (uc.seq)
			SEQ_NEXT: step_d = step_q + step_t'(1);
			SEQ_JUMP: step_d = uc.target;
			SEQ_DISPATCH: begin
				priority if (cmd_xfer && (cmd.func == FUNC_START)) begin
					step_d = uc.target;
				end else if (cmd_xfer && active) begin
					step_d = S_ADV1;
				end else begin
					step_d = step_q;
				end
			end
			SEQ_SETTLE: step_d = r1_done ? step_q + step_t'(1) : uc.target;
			SEQ_RETURN: step_d = fs_q ? uc.target : step_q + step_t'(1);
			SEQ_WAIT:   step_d = emit_free ? uc.target : step_q;
			default:    step_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			fs_q     <= 1'b0;
			br_q     <= 1'b0;
			ctr_x_q  <= '0;
			ctr_y_q  <= '0;
			rad_x_q  <= '0;
			rad_y_q  <= '0;
			rx2_q    <= '0;
			ry2_q    <= '0;
			px_q     <= '0;
			py_q     <= '0;
			snap_x_q <= '0;
			snap_y_q <= '0;
			gx_q     <= '0;
			gy_q     <= '0;
			dec_q    <= '0;
			p_q      <= '0;
			t_q      <= '0;
		end else begin
			if (uc.mul != MUL_NONE) begin
				p_q <= prod[DEC_W-1:0];
			end
			if ((uc.seq == SEQ_RETURN) && fs_q) begin
				fs_q <= 1'b0;
			end
			unique case (uc.dp)
				DP_LOAD: begin
					if (cmd_xfer && (cmd.func == FUNC_START)) begin
						ctr_x_q <= cmd.center_x;
						ctr_y_q <= cmd.center_y;
						rad_x_q <= cmd.radius_x;
						rad_y_q <= cmd.radius_y;
						px_q    <= '0;
						py_q    <= $signed({{(POS_W-RADIUS_BITS){1'b0}}, cmd.radius_y});
						gx_q    <= '0;
						phase_q <= PH_R1;
						fs_q    <= 1'b1;
					end
				end
				DP_LD_RX2: rx2_q <= p_q[SQ_W-1:0];
				DP_LD_RY2: ry2_q <= p_q[SQ_W-1:0];
				DP_INIT_GRAD: begin
					gy_q  <= {p_q[GRAD_W-2:0], 1'b0};
					dec_q <= rx2_d - p4;
				end
				DP_ADD_RY2: dec_q <= dec_q + ry2_4;
				DP_LD_T:    t_q   <= p_q[MUL_W-1:0];
				DP_LD_DEC:  dec_q <= p_q;
				DP_ADD_P:   dec_q <= dec_q + p4;
				DP_SUB_P: begin
					dec_q   <= dec_q - p4;
					phase_q <= PH_R2;
				end
				DP_SETTLE: begin
					if (r2 && py_q[POS_W-1]) begin
						phase_q <= PH_IDLE;
					end
				end
				DP_ADV1: begin
					snap_x_q <= px_q;
					snap_y_q <= py_q;
					if (r1) begin
						px_q <= px_q + POS_W'(1);
						gx_q <= gx_q + ry2_g2;
						br_q <= dec_q[DEC_W-1];
						if (!dec_q[DEC_W-1]) begin
							py_q <= py_q - POS_W'(1);
							gy_q <= gy_q - rx2_g2;
						end
					end else begin
						py_q <= py_q - POS_W'(1);
						gy_q <= gy_q - rx2_g2;
						br_q <= dec_pos;
						if (!dec_pos) begin
							px_q <= px_q + POS_W'(1);
							gx_q <= gx_q + ry2_g2;
						end
					end
				end
				DP_ADV2: dec_q <= dec_q + term_4;
				DP_NOP, DP_HAND: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Output stage: one position, four mirrored pixels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			e_cx_q   <= '0;
			e_cy_q   <= '0;
			e_ox_q   <= '0;
			e_oy_q   <= '0;
			e_done_q <= 1'b0;
		end else begin
			if ((uc.dp == DP_HAND) && emit_free) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				e_cx_q   <= ctr_x_q;
				e_cy_q   <= ctr_y_q;
				e_ox_q   <= snap_x_q;
				e_oy_q   <= snap_y_q;
				e_done_q <= (phase_q == PH_IDLE);
			end else if (pix_xfer) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign cx_e = PIX_W'(e_cx_q);
	assign cy_e = PIX_W'(e_cy_q);
	assign ox_e = PIX_W'(e_ox_q);
	assign oy_e = PIX_W'(e_oy_q);

	assign pix.valid    = busy_q;
	assign pix.pixel_x  = cnt_q[0] ? cx_e - ox_e : cx_e + ox_e;
	assign pix.pixel_y  = cnt_q[1] ? cy_e - oy_e : cy_e + oy_e;
	assign pix.last     = (cnt_q == 2'd3);
	assign pix.done_res = e_done_q;

	// A start always enters the initialization microcode.
	a_start_init: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_xfer && (cmd.func == FUNC_START)) |=> (step_q == S_I1))
		else $error("start transfer did not enter initialization");

	// A step with no ellipse in progress is swallowed.
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_xfer && (cmd.func == FUNC_STEP) && !active) |=> (step_q == S_IDLE))
		else $error("step without an ellipse left the idle step");

	// The row offset stops one below zero; region two ends there.
	a_row_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!(py_q < -1))
		else $error("row offset ran below minus one");

	// The column gradient only grows from zero.
	a_grad_x_sign: assert property (@(posedge clk) disable iff (!arst_n)
		!gx_q[GRAD_W-1])
		else $error("column gradient went negative");

endmodule

// File: dv/midpoint_ellipse_rasterizer_tb.sv
// Self-checking testbench of the midpoint ellipse rasterizer: a pixel scoreboard with its
// own model of the two-region trace, a command driver and a pixel sink with random stalls.
// Depends on mer_pkg, mer_if and midpoint_ellipse_rasterizer.
module midpoint_ellipse_rasterizer_tb;
	import mer_pkg::*;

	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic signed [PIX_W-1:0] x;
		logic signed [PIX_W-1:0] y;
		logic                    last;
		logic                    done;
	} pixel_t;

	class pixel_scoreboard;
		logic [1:0] phase;
		longint     pos_x, pos_y, grad_x, grad_y, dec;
		longint     ctr_x, ctr_y, rad_x, rad_y;
		pixel_t     pending[$];
		int         failures;

		function new();
			phase    = PH_IDLE;
			pos_x    = 0;
			pos_y    = 0;
			grad_x   = 0;
			grad_y   = 0;
			dec      = 0;
			ctr_x    = 0;
			ctr_y    = 0;
			rad_x    = 0;
			rad_y    = 0;
			failures = 0;
		endfunction

		function bit drawing();
			return phase == PH_R1 || phase == PH_R2;
		endfunction

		// Leaves region one once the slope reaches one and ends region two below the axis.
		function void update_region();
			longint rx2, ry2, tx, ty;
			rx2 = rad_x * rad_x;
			ry2 = rad_y * rad_y;
			if (phase == PH_R1 && !(grad_x < grad_y)) begin
				tx    = 2 * pos_x + 1;
				ty    = pos_y - 1;
				dec   = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
				phase = PH_R2;
			end
			if (phase == PH_R2 && pos_y < 0)
				phase = PH_IDLE;
		endfunction

		function void next_position();
			longint rx2, ry2;
			rx2 = rad_x * rad_x;
			ry2 = rad_y * rad_y;
			if (phase == PH_R1) begin
				pos_x  += 1;
				grad_x += 2 * ry2;
				if (dec < 0) begin
					dec += 4 * (grad_x + ry2);
				end else begin
					pos_y  -= 1;
					grad_y -= 2 * rx2;
					dec    += 4 * (grad_x - grad_y + ry2);
				end
			end else begin
				pos_y  -= 1;
				grad_y -= 2 * rx2;
				if (dec > 0) begin
					dec += 4 * (rx2 - grad_y);
				end else begin
					pos_x  += 1;
					grad_x += 2 * ry2;
					dec    += 4 * (grad_x - grad_y + rx2);
				end
			end
			update_region();
		endfunction

		// The four mirrored pixels of the current position; done marks the final one.
		function void emit_pixels();
			logic signed [PIX_W-1:0] xs[4];
			logic signed [PIX_W-1:0] ys[4];
			pixel_t                  p;
			xs[0] = PIX_W'(ctr_x + pos_x); ys[0] = PIX_W'(ctr_y + pos_y);
			xs[1] = PIX_W'(ctr_x - pos_x); ys[1] = PIX_W'(ctr_y + pos_y);
			xs[2] = PIX_W'(ctr_x + pos_x); ys[2] = PIX_W'(ctr_y - pos_y);
			xs[3] = PIX_W'(ctr_x - pos_x); ys[3] = PIX_W'(ctr_y - pos_y);
			next_position();
			for (int k = 0; k < 4; k++) begin
				p.x    = xs[k];
				p.y    = ys[k];
				p.last = (k == 3);
				p.done = (phase == PH_IDLE);
				pending.push_back(p);
			end
		endfunction

		function void accept_command(input logic func, input logic signed [COORD_BITS-1:0] cx,
				input logic signed [COORD_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] rx,
				input logic [RADIUS_BITS-1:0] ry);
			longint rx2, ry2;
			if (func == FUNC_START) begin
				ctr_x  = longint'(cx);
				ctr_y  = longint'(cy);
				rad_x  = longint'(rx);
				rad_y  = longint'(ry);
				rx2    = rad_x * rad_x;
				ry2    = rad_y * rad_y;
				pos_x  = 0;
				pos_y  = rad_y;
				grad_x = 0;
				grad_y = 2 * rx2 * rad_y;
				dec    = 4 * ry2 - 4 * rx2 * rad_y + rx2;
				phase  = PH_R1;
				update_region();
				emit_pixels();
			end else if (drawing()) begin
				emit_pixels();
			end
		endfunction

		function void check_pixel(input logic signed [PIX_W-1:0] x,
				input logic signed [PIX_W-1:0] y, input logic last, input logic done);
			pixel_t want;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: unexpected pixel (%0d,%0d) last=%0b done=%0b",
						$realtime, x, y, last, done);
				return;
			end
			want = pending.pop_front();
			if (x !== want.x || y !== want.y || last !== want.last || done !== want.done) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display({"%0t: pixel mismatch: expected (%0d,%0d) last=%0b done=%0b,",
						" got (%0d,%0d) last=%0b done=%0b"},
						$realtime, want.x, want.y, want.last, want.done, x, y, last, done);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mer_cmd_if cmd ();
	mer_pix_if pix ();

	midpoint_ellipse_rasterizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pix    (pix)
	);

	pixel_scoreboard sb = new();

	int productive;
	bit quiet;
	bit hold_pixels;
	bit hold_started;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Both channels are sampled at the rising edge; a command is noted before a pixel is checked.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
				sb.accept_command(cmd.func, cmd.center_x, cmd.center_y, cmd.radius_x, cmd.radius_y);
			if (pix.valid === 1'b1 && pix.ready === 1'b1)
				sb.check_pixel(pix.pixel_x, pix.pixel_y, pix.last, pix.done_res);
		end
	end

	// Pixel sink: random stall bursts, one long hold on request, none in the quiet part.
	initial begin
		pix.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_pixels) begin
				pix.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_pixels = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				pix.ready = 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end else begin
				pix.ready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_command(input logic func, input logic signed [COORD_BITS-1:0] cx,
			input logic signed [COORD_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] rx,
			input logic [RADIUS_BITS-1:0] ry);
		if (func == FUNC_START || sb.drawing())
			productive++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		cmd.valid    = 1'b1;
		cmd.func     = func;
		cmd.center_x = cx;
		cmd.center_y = cy;
		cmd.radius_x = rx;
		cmd.radius_y = ry;
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		@(negedge clk);
	endtask

	// A start followed by steps until the ellipse is finished or the step budget runs out.
	task automatic draw_ellipse(input logic signed [COORD_BITS-1:0] cx,
			input logic signed [COORD_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] rx,
			input logic [RADIUS_BITS-1:0] ry, input int max_steps);
		int n;
		n = 0;
		send_command(FUNC_START, cx, cy, rx, ry);
		while (sb.drawing() && n < max_steps) begin
			send_command(FUNC_STEP, cx, cy, rx, ry);
			n++;
		end
	endtask

	task automatic noise_step();
		send_command(FUNC_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
			RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
	endtask

	initial begin
		int roll;
		arst_n       = 1'b0;
		cmd.valid    = 1'b0;
		cmd.func     = FUNC_START;
		cmd.center_x = '0;
		cmd.center_y = '0;
		cmd.radius_x = '0;
		cmd.radius_y = '0;
		productive   = 0;
		quiet        = 1'b0;
		hold_pixels  = 1'b0;
		hold_started = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: idle steps, degenerate radii, extreme centers and radii, restarts.
		noise_step();
		draw_ellipse(0, 0, 0, 0, 0);
		noise_step();
		draw_ellipse(16383, -16384, 2047, 2047, 3);
		draw_ellipse(-16384, 16383, 2047, 0, 2);
		draw_ellipse(-16384, -16384, 0, 2047, 3);
		draw_ellipse(0, 0, 5, 0, 2);
		draw_ellipse(100, -50, 3, 2, 20);
		noise_step();

		productive = 0;
		while (productive < RANDOM_ITEMS) begin
			if (!hold_started && productive > RANDOM_ITEMS / 3) begin
				hold_started = 1'b1;
				hold_pixels  = 1'b1;
			end
			if (productive > RANDOM_ITEMS * 3 / 4)
				quiet = 1'b1;
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				noise_step();
			end else if (roll <= 2) begin
				// Large ellipse cut short by the next start.
				draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
					RADIUS_BITS'($urandom_range(0, 2047)),
					RADIUS_BITS'($urandom_range(0, 2047)), $urandom_range(0, 12));
			end else begin
				draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
					RADIUS_BITS'($urandom_range(0, 24)),
					RADIUS_BITS'($urandom_range(0, 24)), 1000);
				repeat ($urandom_range(0, 2)) noise_step();
			end
		end
		cmd.valid = 1'b0;

		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			if (sb.pending.size() != 0)
				$display("pixels never received: %0d", sb.pending.size());
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
design/mer_pkg.sv
design/mer_if.sv
design/midpoint_ellipse_rasterizer.sv
dv/midpoint_ellipse_rasterizer_tb.sv
